// File: rtl/core/sqrot_pkg.sv
// Shared types, register codes and default constants of the square image rotator.
package sqrot_pkg;

  // Fixed field widths of the pixel channels and the configuration port.
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned CFG_DATA_W = 7;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SIDE_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 8;

  // Items that may sit between address generation and the frame store.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Side length after reset.
  localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 7'd64;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_SIDE    = 1'b0,
    REG_QUARTER_TURNS = 1'b1
  } cfg_reg_e;

  // Clockwise quarter turns applied to the output.
  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turns_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
    logic                pixel_valid;
    logic                frame_last;
  } pixel_out_t;

  // Per-item status that travels with the addresses.
  typedef struct packed {
    logic pixel_valid;
    logic frame_last;
  } item_flags_t;

endpackage

// File: rtl/core/sqrot_front.sv
// Front end: configuration registers, raster counters and rotated address generation.
module sqrot_front #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  sqrot_pkg::cfg_reg_e                    cfg_index_i,
  input  logic [sqrot_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output logic [2*$clog2(MAX_SIDE):0]            push_raddr_o,
  output logic [2*$clog2(MAX_SIDE):0]            push_waddr_o,
  output sqrot_pkg::item_flags_t                 push_flags_o
);
  import sqrot_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SIDE);

  logic [CFG_DATA_W-1:0] side_q, side_d;
  turns_e                turns_q, turns_d;
  logic [IW-1:0]         row_q, row_d, col_q, col_d;
  logic                  bank_q, bank_d;
  logic                  ready_q, ready_d;

  logic [IW-1:0] last_w, r_w, c_w, sr_w, sc_w;
  logic          end_row_w, end_frame_w, accept_w;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept_w     = in_valid_i && push_ready_i;

  // Effective last index: a zero side counts as one, a large side saturates.
  always_comb begin
    if (side_q == '0) begin
      last_w = '0;
    end else if (32'(side_q) > MAX_SIDE) begin
      last_w = IW'(MAX_SIDE - 1);
    end else begin
      last_w = IW'(side_q - 7'd1);
    end
  end

  assign r_w = (row_q > last_w) ? last_w : row_q;
  assign c_w = (col_q > last_w) ? last_w : col_q;

  always_comb begin
    unique case (turns_q)
      TURN_90: begin
        sr_w = last_w - c_w;
        sc_w = r_w;
      end
      TURN_180: begin
        sr_w = last_w - r_w;
        sc_w = last_w - c_w;
      end
      TURN_270: begin
        sr_w = c_w;
        sc_w = last_w - r_w;
      end
      TURN_0: begin
        sr_w = r_w;
        sc_w = c_w;
      end
    endcase
  end

  // Row and frame ends compare the raw counters, so a shrunken side ends early.
  assign end_row_w   = (col_q >= last_w);
  assign end_frame_w = end_row_w && (row_q >= last_w);

  assign push_raddr_o              = {~bank_q, sr_w, sc_w};
  assign push_waddr_o              = {bank_q, r_w, c_w};
  assign push_flags_o.pixel_valid  = ready_q;
  assign push_flags_o.frame_last   = end_frame_w;

  always_comb begin
    side_d  = side_q;
    turns_d = turns_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_SIDE:    side_d  = cfg_wdata_i;
        REG_QUARTER_TURNS: turns_d = turns_e'(cfg_wdata_i[1:0]);
      endcase
    end
  end

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    bank_d  = bank_q;
    ready_d = ready_q;
    if (accept_w) begin
      if (end_frame_w) begin
        row_d   = '0;
        col_d   = '0;
        bank_d  = ~bank_q;
        ready_d = 1'b1;
      end else if (end_row_w) begin
        col_d = '0;
        row_d = r_w + 1'b1;
      end else begin
        col_d = c_w + 1'b1;
        row_d = r_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SIDE_RESET;
      turns_q <= TURN_0;
      row_q   <= '0;
      col_q   <= '0;
      bank_q  <= 1'b0;
      ready_q <= 1'b0;
    end else begin
      side_q  <= side_d;
      turns_q <= turns_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bank_q  <= bank_d;
      ready_q <= ready_d;
    end
  end

  // The last item of a frame restarts the raster and swaps the banks.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && end_frame_w |=> row_q == '0 && col_q == '0 && bank_q != $past(bank_q))
    else $error("raster did not wrap after the last item of a frame");

  // Output stays invalid until a whole frame has been written.
  a_valid_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q && !(accept_w && end_frame_w) |=> !ready_q)
    else $error("frame marked ready before a frame completed");

endmodule

// File: rtl/core/sqrot_queue.sv
// Short first-in first-out queue between the front end and the frame store.
module sqrot_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push_w, pop_w;

  assign push_ready_o = (count_q != CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_w) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_w) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_w && !pop_w) begin
      count_d = count_q + 1'b1;
    end else if (pop_w && !push_w) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // A pop without a push frees exactly one slot.
  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_w && !push_w |=> count_q == $past(count_q) - 1'b1)
    else $error("queue fill count wrong after a pop");

endmodule

// File: rtl/core/sqrot_back.sv
// Back end: two-bank frame store with registered read and the output stage.
module sqrot_back #(
  parameter int unsigned MAX_SIDE    = 64,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  logic [2*$clog2(MAX_SIDE):0]    raddr_i,
  input  logic [2*$clog2(MAX_SIDE):0]    waddr_i,
  input  sqrot_pkg::pixel_in_t           pixel_i,
  input  sqrot_pkg::item_flags_t         flags_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sqrot_pkg::pixel_out_t          out_pixel_o
);
  import sqrot_pkg::*;

  localparam int unsigned AW    = 2 * $clog2(MAX_SIDE) + 1;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned SB    = SAMPLE_BITS;

  logic [3*SB-1:0] store_q [Depth];
  logic [3*SB-1:0] rdata_q;
  item_flags_t     flags_q;
  logic            out_valid_q, out_valid_d;
  logic            pop_w;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop_w       = pop_valid_i && pop_ready_o;

  // Write and read hit opposite banks, so they never collide in one cycle.
  always_ff @(posedge clk_i) begin
    if (pop_w) begin
      store_q[waddr_i] <= {SB'(pixel_i.red_in), SB'(pixel_i.green_in), SB'(pixel_i.blue_in)};
      rdata_q          <= store_q[raddr_i];
      flags_q          <= flags_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_w) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // During the first frame the samples read as zero.
  always_comb begin
    out_pixel_o.pixel_valid = flags_q.pixel_valid;
    out_pixel_o.frame_last  = flags_q.frame_last;
    if (flags_q.pixel_valid) begin
      out_pixel_o.red_out   = SAMPLE_W'(rdata_q[3*SB-1 -: SB]);
      out_pixel_o.green_out = SAMPLE_W'(rdata_q[2*SB-1 -: SB]);
      out_pixel_o.blue_out  = SAMPLE_W'(rdata_q[SB-1 -: SB]);
    end else begin
      out_pixel_o.red_out   = '0;
      out_pixel_o.green_out = '0;
      out_pixel_o.blue_out  = '0;
    end
  end

  // Every item taken from the queue shows up in the output register.
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_w |=> out_valid_o)
    else $error("popped item did not reach the output stage");

endmodule

// File: rtl/core/square_image_quarter_turn_rotator.sv
// Top level of the square image rotator: front end, item queue and frame store.
//
// Usage: pixels of a square image enter in raster order on the in_* channel
// (valid/ready). Each accepted item is written into the write half of a
// two-bank frame store, and for each one item of the previous frame leaves on
// the out_* channel, read in raster order through a clockwise rotation of
// quarter_turns * 90 degrees. During the first frame after reset the output
// items carry pixel_valid low and zero samples. frame_last marks the final
// item of every frame, after which the banks swap.
// Configuration: image_side (index 0) and quarter_turns (index 1) are written
// through cfg_we_i, by the user only while the block is idle; the block
// itself does not enforce this. A side of zero acts as one, a side above
// MAX_SIDE saturates. Throughput is one item per clock cycle, sustained
// while the receiver does not stall, set by the frame store doing one write
// and one registered read each cycle. With the queue empty, an accepted item
// is registered in the queue, then popped into the output register (out_valid_o).
// When the receiver stalls, the output register holds the item, the queue
// takes up to two more, and then in_ready_o drops.
// Reset clears counters, bank select and the registers (side 64, no turn);
// the frame store itself is not cleared and needs no clearing pass.
module square_image_quarter_turn_rotator #(
  parameter int unsigned MAX_SIDE    = sqrot_pkg::MAX_SIDE_DEF,
  parameter int unsigned SAMPLE_BITS = sqrot_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  sqrot_pkg::cfg_reg_e              cfg_index_i,
  input  logic [sqrot_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sqrot_pkg::pixel_in_t             in_pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sqrot_pkg::pixel_out_t            out_pixel_o
);
  import sqrot_pkg::*;

  localparam int unsigned AW = 2 * $clog2(MAX_SIDE) + 1;
  localparam int unsigned PX = $bits(pixel_in_t);
  localparam int unsigned FL = $bits(item_flags_t);
  localparam int unsigned EW = 2 * AW + PX + FL;

  logic          push_valid_w, push_ready_w, pop_valid_w, pop_ready_w;
  logic [AW-1:0] push_raddr_w, push_waddr_w;
  item_flags_t   push_flags_w;
  logic [EW-1:0] push_data_w, pop_data_w;

  sqrot_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid_w),
    .push_ready_i (push_ready_w),
    .push_raddr_o (push_raddr_w),
    .push_waddr_o (push_waddr_w),
    .push_flags_o (push_flags_w)
  );

  // Queue entry: read address, write address, incoming pixel, status flags.
  assign push_data_w = {push_raddr_w, push_waddr_w, in_pixel_i, push_flags_w};

  sqrot_queue #(
    .Width (EW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid_w),
    .push_ready_o (push_ready_w),
    .push_data_i  (push_data_w),
    .pop_valid_o  (pop_valid_w),
    .pop_ready_i  (pop_ready_w),
    .pop_data_o   (pop_data_w)
  );

  sqrot_back #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid_w),
    .pop_ready_o (pop_ready_w),
    .raddr_i     (pop_data_w[EW-1 -: AW]),
    .waddr_i     (pop_data_w[EW-AW-1 -: AW]),
    .pixel_i     (pixel_in_t'(pop_data_w[PX+FL-1 -: PX])),
    .flags_i     (item_flags_t'(pop_data_w[FL-1:0])),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the square image quarter-turn rotator.
module testbench;
  import sqrot_pkg::*;

  // The predictor mirrors the block at its default size.
  localparam int unsigned SIDE_MAX     = MAX_SIDE_DEF;
  localparam int unsigned BANK_WORDS   = SIDE_MAX * SIDE_MAX;
  // Largest side used once the output is valid; the warm-up fills this square.
  localparam int unsigned WARM_SIDE    = 16;
  // Items of the saturating first frame that spill into its second row.
  localparam int unsigned WARM_SPILL   = 6;
  localparam int unsigned RANDOM_ITEMS = 970;
  // Length of the one long output hold that fills the block and stalls its input.
  localparam int unsigned LONG_HOLD    = 300;
  // Extra wait after the last owed result, so the block is idle before a register write.
  localparam int unsigned DRAIN_CYCLES = 4;
  // Some fifteen hundred items with their idle and stall gaps, taken many times over.
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef enum logic [0:0] {
    ROW_SET_REG,
    ROW_PIXEL
  } row_kind_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One row of the directed table: either a register write or one pixel item.
  // Where typed is set, want holds the result read straight off the behavior.
  typedef struct packed {
    row_kind_e             kind;
    cfg_reg_e              index;
    logic [CFG_DATA_W-1:0] value;
    pixel_in_t             px;
    logic                  typed;
    pixel_out_t            want;
  } stim_row_t;

  localparam int unsigned DIRECTED_LEN = 34;

  // The directed rows start right after the two warm-up frames, so the
  // write bank is bank 0 and the output is already valid. With a side of one
  // every item is a whole frame, so each result is simply the previous pixel.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{ROW_SET_REG, REG_IMAGE_SIDE,    7'd1,            '0,        1'b0, '0},
    '{ROW_SET_REG, REG_QUARTER_TURNS, 7'(TURN_0),      '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h000000, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hFFFFFF, 1'b1,
      {8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
    // A side of zero behaves as a side of one.
    '{ROW_SET_REG, REG_IMAGE_SIDE,    7'd0,            '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h5AA53C, 1'b1,
      {8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h80017F, 1'b1,
      {8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b1}},
    // Two by two frames through the three nonzero turn counts.
    '{ROW_SET_REG, REG_IMAGE_SIDE,    7'd2,            '0,        1'b0, '0},
    '{ROW_SET_REG, REG_QUARTER_TURNS, 7'(TURN_90),     '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h102030, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h405060, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h708090, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hA0B0C0, 1'b0, '0},
    '{ROW_SET_REG, REG_QUARTER_TURNS, 7'(TURN_180),    '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h0F1E2D, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h3C4B5A, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h697887, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h96A5B4, 1'b0, '0},
    '{ROW_SET_REG, REG_QUARTER_TURNS, 7'(TURN_270),    '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hC3D2E1, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hF00F0F, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h0FF00F, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h010204, 1'b0, '0},
    // Start a three by three frame, then shrink it to two once the column
    // counter sits beyond the new last index, so addressing has to clamp.
    '{ROW_SET_REG, REG_IMAGE_SIDE,    7'd3,            '0,        1'b0, '0},
    '{ROW_SET_REG, REG_QUARTER_TURNS, 7'(TURN_0),      '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h111111, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h222222, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h333333, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h444444, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'h555555, 1'b0, '0},
    '{ROW_SET_REG, REG_IMAGE_SIDE,    7'd2,            '0,        1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hAAAAAA, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hBBBBBB, 1'b0, '0},
    '{ROW_PIXEL,   REG_IMAGE_SIDE,    '0,              24'hCCCCCC, 1'b0, '0}
  };

  // Every block input has a known value from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  cfg_reg_e              cfg_index_i = REG_IMAGE_SIDE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  pixel_in_t             in_pixel_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pixel_out_t            out_pixel_o;

  square_image_quarter_turn_rotator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Reset is asserted once, from time zero, and then released for good.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Predictor state: both banks of the frame store, the raster counters, the
  // bank select and the registers, all as they stand after reset.
  pixel_in_t             store_mem [2 * BANK_WORDS];
  logic [5:0]            row_at     = '0;
  logic [5:0]            col_at     = '0;
  logic                  bank_sel   = 1'b0;
  logic                  frame_done = 1'b0;
  logic [CFG_DATA_W-1:0] side_reg   = SIDE_RESET;
  turns_e                turns_reg  = TURN_0;

  // Results still owed by the block, oldest first.
  pixel_out_t  rotated_pix_q [$];

  int unsigned mismatches     = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_seen    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned stall_pct      = 0;
  int unsigned holds_asked    = 0;

  // Reads the rotated pixel of the previous frame for the current raster
  // position, stores the incoming pixel in the write bank and steps the
  // counters. A counter beyond the side in use is clamped for addressing,
  // while the row and frame ends compare the raw counters.
  function automatic pixel_out_t rotate_from_store(input pixel_in_t px);
    int unsigned n, last, r, c, src_r, src_c;
    bit          end_row, end_frame;
    pixel_out_t  res;
    n    = (side_reg == 0) ? 1 : ((side_reg > SIDE_MAX) ? SIDE_MAX : side_reg);
    last = n - 1;
    r    = (row_at > last) ? last : row_at;
    c    = (col_at > last) ? last : col_at;
    case (turns_reg)
      TURN_90: begin
        src_r = last - c;
        src_c = r;
      end
      TURN_180: begin
        src_r = last - r;
        src_c = last - c;
      end
      TURN_270: begin
        src_r = c;
        src_c = last - r;
      end
      default: begin
        src_r = r;
        src_c = c;
      end
    endcase
    end_row   = (col_at >= last);
    end_frame = end_row && (row_at >= last);

    // Until a whole frame is stored the samples are zero.
    res = '0;
    if (frame_done) begin
      {res.red_out, res.green_out, res.blue_out} =
        store_mem[(bank_sel ? 0 : BANK_WORDS) + src_r * SIDE_MAX + src_c];
    end
    res.pixel_valid = frame_done;
    res.frame_last  = end_frame;

    store_mem[(bank_sel ? BANK_WORDS : 0) + r * SIDE_MAX + c] = px;

    if (end_frame) begin
      row_at     = '0;
      col_at     = '0;
      bank_sel   = ~bank_sel;
      frame_done = 1'b1;
    end else if (end_row) begin
      col_at = '0;
      row_at = 6'(r + 1);
    end else begin
      col_at = 6'(c + 1);
      row_at = 6'(r);
    end
    return res;
  endfunction

  function automatic pixel_in_t random_pixel();
    logic [31:0] raw;
    raw = $urandom;
    return raw[23:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input pixel_out_t got);
    pixel_out_t want;
    results_seen++;
    if (got.frame_last) frames_seen++;
    if (rotated_pix_q.size() == 0) begin
      report_mismatch("item with nothing expected", got, 0);
    end else begin
      want = rotated_pix_q.pop_front();
      if (got.red_out !== want.red_out)
        report_mismatch("red_out", got.red_out, want.red_out);
      if (got.green_out !== want.green_out)
        report_mismatch("green_out", got.green_out, want.green_out);
      if (got.blue_out !== want.blue_out)
        report_mismatch("blue_out", got.blue_out, want.blue_out);
      if (got.pixel_valid !== want.pixel_valid)
        report_mismatch("pixel_valid", got.pixel_valid, want.pixel_valid);
      if (got.frame_last !== want.frame_last)
        report_mismatch("frame_last", got.frame_last, want.frame_last);
    end
  endtask

  // Output side. Results are sampled at the clock edge, before any of the
  // block's registers move, and ready for the next cycle is chosen after.
  // A long hold, once asked for by the stimulus, is counted down here.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result(out_pixel_o);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offers one pixel, after any random idle cycles, and holds it until the
  // block takes it. The expectation is queued at the accepting edge.
  task automatic send_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
    pixel_out_t predicted;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = rotate_from_store(px);
    rotated_pix_q.push_back(typed ? want : predicted);
    items_accepted++;
  endtask

  // Stops offering and waits until every owed result is out, plus the
  // pipeline latency, so that a register write finds the block idle.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rotated_pix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e index, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (index)
      REG_IMAGE_SIDE:    side_reg = value;
      REG_QUARTER_TURNS: turns_reg = turns_e'(value[1:0]);
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER: begin
        send_gap_pct = 49;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 49;
      end
      IDLE_BOTH: begin
        send_gap_pct = 8;
        stall_pct    = 8;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
  endtask

  // Hard stop in case the block hangs or loses results.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed.", cycle_count,
               rotated_pix_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned seg, seg_len, pick, sent_random;
    logic [CFG_DATA_W-1:0] side_pick;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Warm-up: two whole frames. The first one goes out invalid with zero
    // samples. It starts at a side above the maximum, which has to saturate,
    // so one full row of the largest side is written and a few items spill
    // into the second row. The side then drops to WARM_SIDE mid-frame and the
    // frame runs to its end; the second frame reads it back through a turn,
    // which shows where the spilled items landed. Afterwards both banks hold
    // written data over the whole WARM_SIDE square, and no later side is
    // larger, so no read ever hits an unwritten entry.
    set_idling(IDLE_NONE);
    write_register(REG_IMAGE_SIDE, 7'd127);
    write_register(REG_QUARTER_TURNS, 7'(TURN_270));
    repeat (SIDE_MAX + WARM_SPILL) send_pixel(random_pixel(), 1'b0, '0);
    settle_block();
    write_register(REG_IMAGE_SIDE, 7'(WARM_SIDE));
    repeat (WARM_SIDE * WARM_SIDE - WARM_SIDE - WARM_SPILL)
      send_pixel(random_pixel(), 1'b0, '0);
    settle_block();
    set_idling(IDLE_BOTH);
    write_register(REG_QUARTER_TURNS, 7'(TURN_90));
    repeat (WARM_SIDE * WARM_SIDE) send_pixel(random_pixel(), 1'b0, '0);

    // Directed table: small sides, every turn count, side zero, and a
    // side that shrinks mid-frame.
    set_idling(IDLE_NONE);
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_SET_REG) begin
        settle_block();
        write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
      end else begin
        send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    // Random part: segments of random pixels. Between segments the block is
    // drained and the registers may change, so a new side often lands in the
    // middle of a frame, growing as well as shrinking. Small sides dominate
    // so that many frames complete; sides up to WARM_SIDE show up now and
    // then. The idling pattern rotates through the four modes.
    sent_random = 0;
    seg         = 0;
    while (sent_random < RANDOM_ITEMS) begin
      settle_block();
      set_idling(idle_mode_e'(seg % 4));
      if ($urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)
          side_pick = 7'd0;
        else if (pick < 5)
          side_pick = 7'($urandom_range(9, WARM_SIDE));
        else
          side_pick = 7'($urandom_range(1, 8));
        write_register(REG_IMAGE_SIDE, side_pick);
      end
      if ($urandom_range(0, 1) == 1)
        write_register(REG_QUARTER_TURNS, 7'($urandom_range(0, 3)));
      seg_len = $urandom_range(1, 90);
      // One segment runs with a steady sender while the output is held off
      // for a long stretch, so the block fills up and drops its input ready.
      if (seg == 4) begin
        holds_asked++;
        seg_len = 80;
      end
      repeat (seg_len) send_pixel(random_pixel(), 1'b0, '0);
      sent_random += seg_len;
      seg++;
    end
    settle_block();

    $display("Ran %0d pixel items (two warm-up frames, the directed table, %0d random).",
             items_accepted, sent_random);
    $display("Checked %0d results over %0d frames: sides 0 to %0d, one saturating side,",
             results_seen, frames_seen, WARM_SIDE);
    $display("all turns and mid-frame resizes.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
